// ===== rtl/ahd_pkg.sv =====
package ahd_pkg;

  localparam int MAX_PAYLOAD = 1024;

  // payload count and byte position hold 0 .. MAX_PAYLOAD
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  // frame length from extended nibble and two length nibbles: up to 14*256+255
  localparam int TOT_W = 12;
  localparam int CMP_W = ((LEN_W > TOT_W) ? LEN_W : TOT_W) + 1;

  localparam logic [7:0] BYTE_STX      = 8'h02;
  localparam logic [7:0] BYTE_ETX      = 8'h03;
  localparam logic [7:0] BYTE_MARKER   = 8'h33;
  localparam logic [7:0] CHR_OK        = 8'h30;
  localparam logic [7:0] CHR_CHIPIO    = 8'h31;
  localparam logic [7:0] CHR_UNSUP     = 8'h32;
  localparam logic [7:0] CHR_ACTIVATE  = 8'h33;
  localparam logic [7:0] CHR_CONFLICT  = 8'h36;
  localparam logic [7:0] EXT_FLAG_MASK = 8'h80;
  localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_COMM     = 3'd1,
    ST_CHIPIO   = 3'd2,
    ST_UNSUP    = 3'd3,
    ST_ACTIVATE = 3'd4,
    ST_CONFLICT = 3'd5
  } status_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  data_value;
    logic [9:0]  data_index;
    status_t     status_code;
    logic [10:0] payload_length;
  } result_t;

endpackage

// ===== rtl/ascii_hex_response_deframer.sv =====
// channel | ports                                               | direction
// input   | in_valid, in_stall, in_rx_byte                       | byte stream in
// result  | out_valid, out_stall, out_is_status, out_data_value, | decoded words out
//         | out_data_index, out_status_code, out_payload_length  |
//
// One input byte per cycle unless stalled; a byte's result, if any, is registered.
// The frame parser updates its state in the same cycle a byte is accepted.
// A two-word output register with skid stage decouples the sides; in_stall rises
// only while both words are held by a stalled sink.
// Synchronous active-low reset returns the parser to idle and empties the output.
module ascii_hex_response_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_status,
  output logic [7:0]  out_data_value,
  output logic [9:0]  out_data_index,
  output logic [2:0]  out_status_code,
  output logic [10:0] out_payload_length
);

  logic              acc;
  logic              res_vld;
  logic              full;
  ahd_pkg::result_t  res;
  ahd_pkg::result_t  dout;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  ahd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_rx_byte),
    .res_vld (res_vld),
    .res     (res)
  );

  ahd_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && res_vld),
    .din       (res),
    .full      (full),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .dout      (dout)
  );

  assign out_is_status      = dout.is_status;
  assign out_data_value     = dout.data_value;
  assign out_data_index     = dout.data_index;
  assign out_status_code    = dout.status_code;
  assign out_payload_length = dout.payload_length;

endmodule

// ===== rtl/ahd_parser.sv =====
module ahd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          rx_byte,
  output logic                res_vld,
  output ahd_pkg::result_t    res
);

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_LEN_HEAD = 8'b0000_0010,
    PH_LEN_LO   = 8'b0000_0100,
    PH_MARKER   = 8'b0000_1000,
    PH_STATUS   = 8'b0001_0000,
    PH_DATA_HI  = 8'b0010_0000,
    PH_DATA_LO  = 8'b0100_0000,
    PH_END      = 8'b1000_0000
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [3:0]                 mult_r, mult_nxt;
  logic [3:0]                 len_hi_r, len_hi_nxt;
  logic [ahd_pkg::LEN_W-1:0]  remain_r, remain_nxt;
  logic [3:0]                 hold_r, hold_nxt;
  logic [ahd_pkg::LEN_W-1:0]  pos_r, pos_nxt;
  ahd_pkg::status_t           pend_r, pend_nxt;

  logic [3:0]                 lo_nib;
  logic [ahd_pkg::TOT_W-1:0]  total;
  logic [ahd_pkg::CMP_W-1:0]  total_m1;

  assign lo_nib   = rx_byte[3:0];
  assign total    = {4'd0, len_hi_r, lo_nib}
                  + ((mult_r != 4'd0) ? {mult_r - 4'd1, 8'h00} : ahd_pkg::TOT_W'(0));
  assign total_m1 = ahd_pkg::CMP_W'(total) - ahd_pkg::CMP_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    mult_nxt   = mult_r;
    len_hi_nxt = len_hi_r;
    remain_nxt = remain_r;
    hold_nxt   = hold_r;
    pos_nxt    = pos_r;
    pend_nxt   = pend_r;
    res_vld    = 1'b0;
    res        = '0;

    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == ahd_pkg::BYTE_STX) begin
          mult_nxt   = 4'd0;
          len_hi_nxt = 4'd0;
          remain_nxt = '0;
          hold_nxt   = 4'd0;
          pos_nxt    = '0;
          pend_nxt   = ahd_pkg::ST_OK;
          phase_nxt  = PH_LEN_HEAD;
        end
      end
      PH_LEN_HEAD: begin
        if (mult_r == 4'd0 && (rx_byte & ahd_pkg::EXT_FLAG_MASK) != 8'd0) begin
          if (lo_nib == 4'd0) begin
            res_vld         = 1'b1;
            res.is_status   = 1'b1;
            res.status_code = ahd_pkg::ST_COMM;
            phase_nxt       = PH_IDLE;
          end else begin
            mult_nxt = lo_nib;
          end
        end else begin
          len_hi_nxt = lo_nib;
          phase_nxt  = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (total == '0 || total_m1 > ahd_pkg::CMP_W'(ahd_pkg::MAX_PAYLOAD)) begin
          res_vld         = 1'b1;
          res.is_status   = 1'b1;
          res.status_code = ahd_pkg::ST_COMM;
          phase_nxt       = PH_IDLE;
        end else begin
          remain_nxt = ahd_pkg::LEN_W'(total_m1);
          phase_nxt  = PH_MARKER;
        end
      end
      PH_MARKER: begin
        if (rx_byte != ahd_pkg::BYTE_MARKER) begin
          res_vld         = 1'b1;
          res.is_status   = 1'b1;
          res.status_code = ahd_pkg::ST_COMM;
          phase_nxt       = PH_IDLE;
        end else begin
          phase_nxt = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (rx_byte == ahd_pkg::CHR_OK) begin
          pend_nxt  = ahd_pkg::ST_OK;
          phase_nxt = (remain_r == '0) ? PH_END : PH_DATA_HI;
        end else begin
          res_vld       = 1'b1;
          res.is_status = 1'b1;
          phase_nxt     = PH_IDLE;
          case (rx_byte)
            ahd_pkg::CHR_CHIPIO:   res.status_code = ahd_pkg::ST_CHIPIO;
            ahd_pkg::CHR_UNSUP:    res.status_code = ahd_pkg::ST_UNSUP;
            ahd_pkg::CHR_ACTIVATE: res.status_code = ahd_pkg::ST_ACTIVATE;
            ahd_pkg::CHR_CONFLICT: res.status_code = ahd_pkg::ST_CONFLICT;
            default:               res.status_code = ahd_pkg::ST_COMM;
          endcase
        end
      end
      PH_DATA_HI: begin
        hold_nxt  = lo_nib;
        phase_nxt = PH_DATA_LO;
      end
      PH_DATA_LO: begin
        res_vld        = 1'b1;
        res.data_value = {hold_r, lo_nib};
        res.data_index = 10'(pos_r);
        pos_nxt        = pos_r + ahd_pkg::LEN_W'(1);
        if (remain_r != '0) begin
          remain_nxt = remain_r - ahd_pkg::LEN_W'(1);
        end
        phase_nxt = (remain_r <= ahd_pkg::LEN_W'(1)) ? PH_END : PH_DATA_HI;
      end
      PH_END: begin
        res_vld       = 1'b1;
        res.is_status = 1'b1;
        phase_nxt     = PH_IDLE;
        if (rx_byte != ahd_pkg::BYTE_ETX) begin
          res.status_code = ahd_pkg::ST_COMM;
        end else begin
          res.status_code    = pend_r;
          res.payload_length = 11'(pos_r);
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      mult_r   <= 4'd0;
      len_hi_r <= 4'd0;
      remain_r <= '0;
      hold_r   <= 4'd0;
      pos_r    <= '0;
      pend_r   <= ahd_pkg::ST_OK;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      mult_r   <= mult_nxt;
      len_hi_r <= len_hi_nxt;
      remain_r <= remain_nxt;
      hold_r   <= hold_nxt;
      pos_r    <= pos_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // a data word only comes from the low-nibble phase
  a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && !res.is_status) |-> (phase_r == PH_DATA_LO))
    else $error("data word outside low-nibble phase");

  // each accepted low nibble advances the byte position by one
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == PH_DATA_LO) |=> (pos_r == $past(pos_r) + ahd_pkg::LEN_W'(1)))
    else $error("byte position did not advance");

  // the payload never runs past its announced length
  a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA_HI || phase_r == PH_DATA_LO) |-> (remain_r != '0))
    else $error("data phase with no bytes remaining");

endmodule

// ===== rtl/ahd_out_skid.sv =====
module ahd_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ahd_pkg::result_t   din,
  output logic               full,
  output logic               out_vld,
  input  logic               out_stall,
  output ahd_pkg::result_t   dout
);

  logic              main_vld_r;
  logic              skid_vld_r;
  ahd_pkg::result_t  main_r;
  ahd_pkg::result_t  skid_r;
  logic              main_free;

  assign main_free = !main_vld_r || !out_stall;
  assign full      = skid_vld_r;
  assign out_vld   = main_vld_r;
  assign dout      = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (main_free) begin
      main_vld_r <= skid_vld_r || push;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_vld_r ? skid_r : din;
    end else if (push) begin
      skid_r <= din;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid word without a word in the output register");

  // the source must hold off while the skid stage is occupied
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && skid_vld_r))
    else $error("word pushed into a full skid stage");

  // a held skid word moves to the output once the sink takes the current one
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_stall) |=> (main_vld_r && !skid_vld_r))
    else $error("skid word not drained");

endmodule

// ===== tb/ascii_hex_response_deframer_tb.sv =====
`timescale 1ns / 100ps

module ascii_hex_response_deframer_tb;

  typedef enum logic [2:0] {
    P_IDLE, P_LEN_HEAD, P_LEN_LO, P_MARKER, P_STATUS, P_DATA_HI, P_DATA_LO, P_END
  } parse_phase_t;

  typedef enum {
    FLT_NONE, FLT_MARKER, FLT_END, FLT_ZERO_LEN, FLT_EXT_ZERO, FLT_OVERSIZE
  } frame_fault_t;

  localparam int MAX_TOTAL = 14 * 256 + 255;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_status;
  logic [7:0]  out_data_value;
  logic [9:0]  out_data_index;
  logic [2:0]  out_status_code;
  logic [10:0] out_payload_length;

  ascii_hex_response_deframer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_status      (out_is_status),
    .out_data_value     (out_data_value),
    .out_data_index     (out_data_index),
    .out_status_code    (out_status_code),
    .out_payload_length (out_payload_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]        rx_stream[$];
  ahd_pkg::result_t  pending_words[$];
  int                frame_bytes = 0;
  int                mismatch_count = 0;
  bit                byte_taken = 1'b0;
  bit                idle_on = 1'b1;
  int                send_gap = 0;
  int                sink_hold = 0;
  int                tick = 0;

  logic [7:0] fail_chr [4] = '{ahd_pkg::CHR_CHIPIO, ahd_pkg::CHR_UNSUP,
                               ahd_pkg::CHR_ACTIVATE, ahd_pkg::CHR_CONFLICT};

  // parser state mirror
  parse_phase_t      parse_phase = P_IDLE;
  logic [3:0]        ext_nib = '0;
  logic [3:0]        len_hi = '0;
  int                bytes_left = 0;
  logic [3:0]        hold_nib = '0;
  int                byte_pos = 0;
  ahd_pkg::status_t  end_status = ahd_pkg::ST_OK;

  task automatic push_status(input ahd_pkg::status_t code, input int len);
    ahd_pkg::result_t r;
    r = '0;
    r.is_status = 1'b1;
    r.status_code = code;
    r.payload_length = 11'(len);
    pending_words.push_back(r);
    parse_phase = P_IDLE;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    int total;
    ahd_pkg::result_t r;
    case (parse_phase)
      P_IDLE: if (b == ahd_pkg::BYTE_STX) begin
        ext_nib = '0;
        len_hi = '0;
        bytes_left = 0;
        hold_nib = '0;
        byte_pos = 0;
        end_status = ahd_pkg::ST_OK;
        parse_phase = P_LEN_HEAD;
      end
      P_LEN_HEAD: begin
        if (ext_nib == 0 && (b & ahd_pkg::EXT_FLAG_MASK) != 0) begin
          if ((b & ahd_pkg::NIBBLE_MASK) == 0) push_status(ahd_pkg::ST_COMM, 0);
          else ext_nib = b[3:0];
        end else begin
          len_hi = b[3:0];
          parse_phase = P_LEN_LO;
        end
      end
      P_LEN_LO: begin
        total = int'({len_hi, b[3:0]});
        if (ext_nib != 0) total += 256 * (int'(ext_nib) - 1);
        if (total == 0 || total - 1 > ahd_pkg::MAX_PAYLOAD) begin
          push_status(ahd_pkg::ST_COMM, 0);
        end else begin
          bytes_left = total - 1;
          parse_phase = P_MARKER;
        end
      end
      P_MARKER: begin
        if (b != ahd_pkg::BYTE_MARKER) push_status(ahd_pkg::ST_COMM, 0);
        else parse_phase = P_STATUS;
      end
      P_STATUS: begin
        case (b)
          ahd_pkg::CHR_OK: begin
            end_status = ahd_pkg::ST_OK;
            parse_phase = (bytes_left == 0) ? P_END : P_DATA_HI;
          end
          ahd_pkg::CHR_CHIPIO:   push_status(ahd_pkg::ST_CHIPIO, 0);
          ahd_pkg::CHR_UNSUP:    push_status(ahd_pkg::ST_UNSUP, 0);
          ahd_pkg::CHR_ACTIVATE: push_status(ahd_pkg::ST_ACTIVATE, 0);
          ahd_pkg::CHR_CONFLICT: push_status(ahd_pkg::ST_CONFLICT, 0);
          default:               push_status(ahd_pkg::ST_COMM, 0);
        endcase
      end
      P_DATA_HI: begin
        hold_nib = b[3:0];
        parse_phase = P_DATA_LO;
      end
      P_DATA_LO: begin
        r = '0;
        r.data_value = {hold_nib, b[3:0]};
        r.data_index = 10'(byte_pos);
        pending_words.push_back(r);
        byte_pos++;
        if (bytes_left > 0) bytes_left--;
        parse_phase = (bytes_left == 0) ? P_END : P_DATA_HI;
      end
      default: begin
        if (b != ahd_pkg::BYTE_ETX) push_status(ahd_pkg::ST_COMM, 0);
        else push_status(end_status, byte_pos);
      end
    endcase
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return {4'($urandom), n};
  endfunction

  task automatic push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    frame_bytes++;
  endtask

  // idle noise: anything but a start byte
  task automatic queue_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom); while (b == ahd_pkg::BYTE_STX);
      push_byte(b);
    end
  endtask

  task automatic queue_frame(input int payload, input bit use_ext, input frame_fault_t flt,
                             input logic [7:0] status_chr);
    int total;
    logic [7:0] b;
    logic [7:0] v;
    total = (flt == FLT_ZERO_LEN) ? 0 : payload + 1;
    if (total > 255) use_ext = 1'b1;
    push_byte(ahd_pkg::BYTE_STX);
    if (flt == FLT_EXT_ZERO) begin
      push_byte({1'b1, 3'($urandom), 4'h0});
      return;
    end
    if (use_ext) begin
      push_byte({1'b1, 3'($urandom), 4'((total >> 8) + 1)});
      // bit 7 here is only a length nibble carrier
      push_byte(hex_char(4'(total >> 4)));
    end else begin
      push_byte({1'b0, 3'($urandom), 4'(total >> 4)});
    end
    push_byte(hex_char(4'(total)));
    if (flt == FLT_ZERO_LEN || flt == FLT_OVERSIZE) return;
    if (flt == FLT_MARKER) begin
      do b = 8'($urandom); while (b == ahd_pkg::BYTE_MARKER);
      push_byte(b);
      return;
    end
    push_byte(ahd_pkg::BYTE_MARKER);
    push_byte(status_chr);
    if (status_chr != ahd_pkg::CHR_OK) return;
    for (int i = 0; i < payload; i++) begin
      v = 8'($urandom);
      push_byte(hex_char(v[7:4]));
      push_byte(hex_char(v[3:0]));
    end
    if (flt == FLT_END) begin
      do b = 8'($urandom); while (b == ahd_pkg::BYTE_ETX);
    end else begin
      b = ahd_pkg::BYTE_ETX;
    end
    push_byte(b);
  endtask

  // driver: bytes in, sink stall out, both at the falling edge
  always @(negedge clk) begin : drive
    bit calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
      send_gap <= 0;
      sink_hold <= 0;
    end else begin
      tick <= tick + 1;
      if (tick % 256 == 0) idle_on <= ($urandom_range(0, 3) != 0);
      calm = !idle_on || rx_stream.size() < 300;

      if (in_valid && !byte_taken) begin
        // hold the stalled word
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (rx_stream.size() != 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_stream.pop_front();
        if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end

      if (calm) begin
        out_stall <= 1'b0;
        sink_hold <= 0;
      end else if (sink_hold > 0) begin
        out_stall <= 1'b1;
        sink_hold <= sink_hold - 1;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        sink_hold <= $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic bit field_ok(input string nm, input logic [10:0] want,
                                  input logic [10:0] got);
    if (got === want) return 1'b1;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, nm, want, got);
    return 1'b0;
  endfunction

  // monitor: predict on accepted bytes, check accepted words
  always @(posedge clk) begin : monitor
    ahd_pkg::result_t want;
    bit ok;
    if (!rst_n) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual status=%0b value=%0d index=%0d",
                   $time, out_is_status, out_data_value, out_data_index);
          mismatch_count++;
        end else begin
          want = pending_words.pop_front();
          ok = field_ok("is_status", 11'(want.is_status), 11'(out_is_status));
          ok &= field_ok("data_value", 11'(want.data_value), 11'(out_data_value));
          ok &= field_ok("data_index", 11'(want.data_index), 11'(out_data_index));
          ok &= field_ok("status_code", 11'(want.status_code), 11'(out_status_code));
          ok &= field_ok("payload_length", want.payload_length, out_payload_length);
          if (!ok) mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int payload;
    int pick;
    frame_fault_t flt;
    logic [7:0] chr;

    queue_noise(3);
    queue_frame(0, 1'b0, FLT_NONE, ahd_pkg::CHR_OK);
    queue_frame(1, 1'b0, FLT_NONE, ahd_pkg::CHR_OK);
    queue_frame(3, 1'b1, FLT_NONE, ahd_pkg::CHR_OK);
    queue_frame(15, 1'b0, FLT_NONE, ahd_pkg::CHR_OK);
    queue_frame(254, 1'b0, FLT_NONE, ahd_pkg::CHR_OK);
    queue_frame(300, 1'b1, FLT_NONE, ahd_pkg::CHR_OK);
    queue_frame(2, 1'b0, FLT_MARKER, ahd_pkg::CHR_OK);
    queue_frame(2, 1'b0, FLT_NONE, 8'h35);
    queue_frame(2, 1'b1, FLT_NONE, 8'hFF);
    for (int i = 0; i < 4; i++) queue_frame(2, i[0], FLT_NONE, fail_chr[i]);
    queue_frame(2, 1'b0, FLT_END, ahd_pkg::CHR_OK);
    queue_frame(0, 1'b0, FLT_ZERO_LEN, ahd_pkg::CHR_OK);
    queue_frame(0, 1'b1, FLT_ZERO_LEN, ahd_pkg::CHR_OK);
    queue_frame(0, 1'b0, FLT_EXT_ZERO, ahd_pkg::CHR_OK);
    queue_frame(ahd_pkg::MAX_PAYLOAD + 1, 1'b1, FLT_OVERSIZE, ahd_pkg::CHR_OK);
    queue_frame(MAX_TOTAL - 1, 1'b1, FLT_OVERSIZE, ahd_pkg::CHR_OK);

    // fill the rest of the byte budget with mostly short frames
    while (frame_bytes < 1500) begin
      if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 4));
      payload = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 300) : $urandom_range(0, 12);
      case ($urandom_range(0, 11))
        0: flt = FLT_MARKER;
        1: flt = FLT_END;
        2: flt = FLT_ZERO_LEN;
        3: flt = FLT_EXT_ZERO;
        4: begin
          flt = FLT_OVERSIZE;
          payload = $urandom_range(ahd_pkg::MAX_PAYLOAD + 1, MAX_TOTAL - 1);
        end
        default: flt = FLT_NONE;
      endcase
      pick = $urandom_range(0, 15);
      if (pick < 2) chr = fail_chr[$urandom_range(0, 3)];
      else if (pick == 2) chr = 8'($urandom);
      else chr = ahd_pkg::CHR_OK;
      queue_frame(payload, $urandom_range(0, 3) == 0, flt, chr);
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (rx_stream.size() != 0 || in_valid) @(negedge clk);
    while (pending_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** ascii_hex_response_deframer: PASSED **");
    end else begin
      $display("** ascii_hex_response_deframer: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("** ascii_hex_response_deframer: FAILED **");
    $finish;
  end

endmodule
